>>> rtl/phsc_pkg.sv
// shared types, constants and helpers for the peak-hold strip-chart binner
`default_nettype none
package phsc_pkg;

  localparam int MAX_COLUMNS_DEF = 1024;
  localparam int TIME_BITS_DEF   = 48;
  localparam int MAX_COLUMNS_HI  = 4096;
  localparam int COL_IDX_BITS    = $clog2(MAX_COLUMNS_HI);
  localparam int WIDTH_BITS      = COL_IDX_BITS + 1;

  localparam int CUR_BITS        = 16;
  localparam int VOLT_BITS       = 16;
  localparam int TIME_FIELD_BITS = 48;
  localparam int READ_COL_BITS   = 10;
  localparam int MODE_BITS       = 2;

  localparam int CFG_IDX_BITS    = 2;
  localparam int CFG_DATA_BITS   = 16;
  localparam int INTERVAL_BITS   = 16;
  localparam int COLS_REG_BITS   = 11;
  localparam int INTERVAL_RESET  = 100;
  localparam int COLS_RESET      = 1024;

  localparam int FIFO_DEPTH      = 2;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_REBUILD, MODE_ADVANCE, MODE_SAMPLE, MODE_READ
  } mode_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_INTERVAL, REG_LOG_SCALE, REG_COLUMNS
  } reg_idx_t;

  typedef enum logic [2:0] {
    CMD_NOP, CMD_WIPE, CMD_SHIFT, CMD_SAMPLE, CMD_READ
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t                 op;
    logic [COL_IDX_BITS-1:0] col;
    logic [CUR_BITS-1:0]     cur;
    logic [VOLT_BITS-1:0]    volt;
  } cmd_t;

  typedef struct packed {
    logic                  valid;
    logic [CUR_BITS-1:0]   cur;
    logic [VOLT_BITS-1:0]  volt;
  } entry_t;

  typedef struct packed {
    logic                  cols_wr;
    logic [WIDTH_BITS-1:0] new_w;
  } cfg_ev_t;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} front_state_t;

  typedef enum logic [3:0] {
    B_IDLE, B_CLR, B_WIPE, B_SH, B_SHLAST, B_SHCLR, B_SRD, B_SWR,
    B_RRD, B_RCAP, B_SW, B_SWEND, B_OUT
  } back_state_t;

  // floor(w / 6) by reciprocal, exact for w below 32768
  function automatic logic [WIDTH_BITS-1:0] div6(input logic [WIDTH_BITS-1:0] w);
    logic [31:0] p;
    p = 32'(w) * 32'd10923;
    return WIDTH_BITS'(p >> 16);
  endfunction

endpackage
`default_nettype wire

>>> rtl/phsc_if.sv
// input and result channel interfaces
`default_nettype none
interface phsc_in_if import phsc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [MODE_BITS-1:0]       mode;
  logic [TIME_FIELD_BITS-1:0] view_right_ms;
  logic [TIME_FIELD_BITS-1:0] sample_time_ms;
  logic [CUR_BITS-1:0]        sample_current;
  logic [VOLT_BITS-1:0]       sample_voltage;
  logic [READ_COL_BITS-1:0]   read_column;
  modport source (output valid, mode, view_right_ms, sample_time_ms, sample_current,
                  sample_voltage, read_column, input ready);
  modport sink (input valid, mode, view_right_ms, sample_time_ms, sample_current,
                sample_voltage, read_column, output ready);
endinterface

interface phsc_out_if import phsc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CUR_BITS-1:0]  col_current;
  logic [VOLT_BITS-1:0] col_voltage;
  logic                 col_valid;
  logic [CUR_BITS-1:0]  min_current;
  logic [CUR_BITS-1:0]  max_current;
  logic                 has_data;
  modport source (output valid, col_current, col_voltage, col_valid, min_current,
                  max_current, has_data, input ready);
  modport sink (input valid, col_current, col_voltage, col_valid, min_current,
                max_current, has_data, output ready);
endinterface
`default_nettype wire

>>> rtl/phsc_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module phsc_div import phsc_pkg::*; #(
  parameter int N = TIME_BITS_DEF,
  parameter int D = INTERVAL_BITS
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [N-1:0] dividend,
  input  wire logic [D-1:0] divisor,
  output logic              done,
  output logic [N-1:0]      quot,
  output logic [D-1:0]      rem
);
  localparam int CNTW = $clog2(N + 1);

  logic [N-1:0]    q_r;
  logic [D-1:0]    r_r, d_r, r_nxt;
  logic [CNTW-1:0] cnt_r;
  logic            run_r, done_r, ge;
  logic [D:0]      shifted;

  always_comb begin
    shifted = {r_r, q_r[N-1]};
    ge      = shifted >= {1'b0, d_r};
    r_nxt   = ge ? D'(shifted - {1'b0, d_r}) : D'(shifted);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNTW'(N);
      end else if (run_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend;
      r_r <= '0;
      d_r <= divisor;
    end else if (run_r) begin
      q_r <= {q_r[N-2:0], ge};
      r_r <= r_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r;
endmodule
`default_nettype wire

>>> rtl/phsc_front.sv
// front end: accepts items, tracks view edge, maps samples to columns
`default_nettype none
module phsc_front import phsc_pkg::*; #(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF,
  localparam int CW = $clog2(MAX_COLUMNS + 1)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  phsc_in_if.sink                       in_ch,
  input  wire logic                     clr_busy,
  input  wire logic                     edge_clr,
  input  wire logic [INTERVAL_BITS-1:0] interval,
  input  wire logic                     log_scale,
  input  wire logic [CW-1:0]            w,
  output logic                          push_valid,
  input  wire logic                     push_ready,
  output cmd_t                          push_cmd
);
  localparam int TB  = TIME_BITS;
  localparam int THW = CW + 5;

  front_state_t           state_r, state_nxt;
  logic [TB-1:0]          re_r, re_nxt, t_r, t_nxt;
  logic [CW-1:0]          fill_r, fill_nxt, base_r;
  logic                   hold_r, hold_nxt, fwd_r, fwd_nxt;
  mode_t                  mode_r, mode_nxt;
  logic [CUR_BITS-1:0]    cur_r, cur_nxt;
  logic [VOLT_BITS-1:0]   volt_r, volt_nxt;
  cmd_t                   cmd_r, cmd_nxt;

  logic                     acc, div_start, div_done;
  logic [TB-1:0]            div_a, div_q, t_in;
  logic [INTERVAL_BITS-1:0] unit, div_rem;

  assign in_ch.ready = (state_r == F_IDLE) && !clr_busy;
  assign acc         = in_ch.valid && in_ch.ready;
  assign unit        = (interval == '0) ? INTERVAL_BITS'(1) : interval;
  assign push_valid  = (state_r == F_PUSH);
  assign push_cmd    = cmd_r;

  phsc_div #(.N(TB), .D(INTERVAL_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (unit),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_rem)
  );

  always_comb begin
    logic [TB:0]    qc;
    logic [CW-1:0]  s, lim;
    logic [THW-1:0] b, t1, t2, t3, t4, t5, al, col;
    logic           col_ok;
    state_nxt = state_r;
    re_nxt    = re_r;
    fill_nxt  = fill_r;
    hold_nxt  = hold_r;
    mode_nxt  = mode_r;
    t_nxt     = t_r;
    cur_nxt   = cur_r;
    volt_nxt  = volt_r;
    fwd_nxt   = fwd_r;
    cmd_nxt   = cmd_r;
    div_start = 1'b0;
    div_a     = '0;
    t_in      = (mode_t'(in_ch.mode) == MODE_SAMPLE) ? TB'(in_ch.sample_time_ms)
                                                       : TB'(in_ch.view_right_ms);
    qc     = {1'b0, div_q} + (TB + 1)'(div_rem != '0);
    s      = CW'(div_q);
    lim    = (fill_r < w) ? fill_r : w;
    b      = THW'(base_r);
    t1     = b << 1;
    t2     = b << 2;
    t3     = b << 3;
    t4     = b << 4;
    t5     = (THW'(w) << 4) - (b << 6);
    al     = THW'(div_q);
    col    = '0;
    col_ok = 1'b0;
    case (state_r)
      F_IDLE: begin
        if (acc) begin
          mode_nxt  = mode_t'(in_ch.mode);
          t_nxt     = t_in;
          cur_nxt   = in_ch.sample_current;
          volt_nxt  = in_ch.sample_voltage;
          cmd_nxt   = '0;
          state_nxt = F_PUSH;
          case (mode_t'(in_ch.mode))
            MODE_REBUILD: begin
              if (w != '0) begin
                re_nxt      = t_in;
                fill_nxt    = w;
                hold_nxt    = 1'b0;
                cmd_nxt.op  = CMD_WIPE;
              end
            end
            MODE_ADVANCE: begin
              if (w != '0) begin
                if (re_r == '0 || log_scale) begin
                  re_nxt     = t_in;
                  fill_nxt   = w;
                  hold_nxt   = 1'b0;
                  cmd_nxt.op = CMD_WIPE;
                end else begin
                  div_start = 1'b1;
                  fwd_nxt   = t_in >= re_r;
                  div_a     = (t_in >= re_r) ? t_in - re_r : re_r - t_in;
                  state_nxt = F_DIV;
                end
              end
            end
            MODE_SAMPLE: begin
              if (t_in <= re_r) begin
                div_start = 1'b1;
                div_a     = re_r - t_in;
                state_nxt = F_DIV;
              end
            end
            MODE_READ: begin
              if (32'(in_ch.read_column) < 32'(w)) begin
                cmd_nxt.op  = CMD_READ;
                cmd_nxt.col = COL_IDX_BITS'(in_ch.read_column);
              end
            end
            default: ;
          endcase
        end
      end
      F_DIV: begin
        if (div_done) begin
          state_nxt = F_PUSH;
          case (mode_r)
            MODE_ADVANCE: begin
              if ((fwd_r && div_q >= TB'(w)) || (!fwd_r && qc >= (TB + 1)'(w))) begin
                re_nxt     = t_r;
                fill_nxt   = w;
                hold_nxt   = 1'b0;
                cmd_nxt.op = CMD_WIPE;
              end else if (fwd_r) begin
                if (s != '0) begin
                  cmd_nxt.op  = CMD_SHIFT;
                  cmd_nxt.col = COL_IDX_BITS'(s);
                end
                fill_nxt = ((s > CW'(1)) ? s : CW'(1)) + CW'(1);
                hold_nxt = (s == '0);
                re_nxt   = t_r;
              end else begin
                fill_nxt = CW'(2);
                hold_nxt = 1'b0;
                re_nxt   = t_r;
              end
            end
            MODE_SAMPLE: begin
              if (log_scale) begin
                col_ok = div_q < TB'(t5);
                if (div_q < TB'(t1))      col = al;
                else if (div_q < TB'(t2)) col = t1 + ((al - t1) >> 1);
                else if (div_q < TB'(t3)) col = (b * THW'(3)) + ((al - t2) >> 2);
                else if (div_q < TB'(t4)) col = t2 + ((al - t3) >> 3);
                else                      col = (b * THW'(5)) + ((al - t4) >> 4);
              end else begin
                col_ok = div_q < TB'(w);
                col    = al;
              end
              if (col_ok && CW'(col) < lim && !(hold_r && col == '0)) begin
                cmd_nxt.op   = CMD_SAMPLE;
                cmd_nxt.col  = COL_IDX_BITS'(col);
                cmd_nxt.cur  = cur_r;
                cmd_nxt.volt = volt_r;
              end
            end
            default: ;
          endcase
        end
      end
      F_PUSH: begin
        if (push_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      re_r    <= '0;
      fill_r  <= '0;
      hold_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      re_r    <= edge_clr ? '0 : re_nxt;
      fill_r  <= fill_nxt;
      hold_r  <= hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    t_r    <= t_nxt;
    cur_r  <= cur_nxt;
    volt_r <= volt_nxt;
    fwd_r  <= fwd_nxt;
    cmd_r  <= cmd_nxt;
    base_r <= CW'(div6(WIDTH_BITS'(w)));
  end
endmodule
`default_nettype wire

>>> rtl/phsc_fifo.sv
// short command queue between front and back
`default_nettype none
module phsc_fifo import phsc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  output logic      push_ready,
  input  cmd_t      push_cmd,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output cmd_t      pop_cmd
);
  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int NW = $clog2(FIFO_DEPTH + 1);

  cmd_t          slot_r [FIFO_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [NW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign push_ready = cnt_r != NW'(FIFO_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_cmd    = slot_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PW'(FIFO_DEPTH - 1)) ? '0 : wp_r + PW'(1);
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(FIFO_DEPTH - 1)) ? '0 : rp_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + NW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end
endmodule
`default_nettype wire

>>> rtl/phsc_back.sv
// back end: column memory, scroll, peak update, min/max sweep, result register
`default_nettype none
module phsc_back import phsc_pkg::*; #(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  localparam int CW = $clog2(MAX_COLUMNS + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          pop_valid,
  output logic               pop_ready,
  input  cmd_t               pop_cmd,
  input  cfg_ev_t            cfg_ev,
  input  wire logic [CW-1:0] w,
  output logic               clr_busy,
  phsc_out_if.source         out_ch
);
  localparam int AW = $clog2(MAX_COLUMNS);

  entry_t mem [MAX_COLUMNS];
  entry_t rd_r, wd;
  logic   we;
  logic [AW-1:0] wa, ra;

  back_state_t state_r, state_nxt;
  logic          pend_r, pend_nxt;
  logic [CW-1:0] pend_from_r, pend_from_nxt, new_w;
  logic [AW-1:0] ctr_r, ctr_nxt, s_r, s_nxt, wa_r, wa_nxt, last;
  cmd_t          cmd_r, cmd_nxt;
  logic          wr_pend_r, wr_pend_nxt, sw_pend_r, sw_pend_nxt;
  logic          any_r, any_nxt, ok_r, ok_nxt, acc_any;
  logic [CUR_BITS-1:0]  mn_r, mn_nxt, mx_r, mx_nxt, cc_r, cc_nxt, acc_mn, acc_mx;
  logic [VOLT_BITS-1:0] cv_r, cv_nxt;
  logic          load, ov_r;
  logic [CUR_BITS-1:0]  o_cc_r, o_mn_r, o_mx_r;
  logic [VOLT_BITS-1:0] o_cv_r;
  logic          o_ok_r, o_any_r;

  assign clr_busy = pend_r;
  assign new_w    = CW'(cfg_ev.new_w);
  assign last     = AW'(w - CW'(1));

  always_comb begin
    acc_any = any_r;
    acc_mn  = mn_r;
    acc_mx  = mx_r;
    if (rd_r.valid) begin
      acc_any = 1'b1;
      acc_mn  = (!any_r || rd_r.cur < mn_r) ? rd_r.cur : mn_r;
      acc_mx  = (!any_r || rd_r.cur > mx_r) ? rd_r.cur : mx_r;
    end
  end

  always_comb begin
    logic sweep;
    sweep         = 1'b0;
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    pend_from_nxt = pend_from_r;
    ctr_nxt       = ctr_r;
    s_nxt         = s_r;
    wa_nxt        = wa_r;
    cmd_nxt       = cmd_r;
    wr_pend_nxt   = wr_pend_r;
    sw_pend_nxt   = sw_pend_r;
    any_nxt       = any_r;
    mn_nxt        = mn_r;
    mx_nxt        = mx_r;
    cc_nxt        = cc_r;
    cv_nxt        = cv_r;
    ok_nxt        = ok_r;
    pop_ready     = 1'b0;
    load          = 1'b0;
    we            = 1'b0;
    wa            = ctr_r;
    wd            = '0;
    ra            = ctr_r;
    case (state_r)
      B_IDLE: begin
        if (pend_r) begin
          if (32'(pend_from_r) >= 32'(MAX_COLUMNS)) begin
            pend_nxt = 1'b0;
          end else begin
            ctr_nxt   = AW'(pend_from_r);
            state_nxt = B_CLR;
          end
        end else if (pop_valid) begin
          pop_ready = 1'b1;
          cmd_nxt   = pop_cmd;
          cc_nxt    = '0;
          cv_nxt    = '0;
          ok_nxt    = 1'b0;
          case (pop_cmd.op)
            CMD_WIPE: begin
              ctr_nxt   = '0;
              state_nxt = B_WIPE;
            end
            CMD_SHIFT: begin
              s_nxt       = AW'(pop_cmd.col);
              ctr_nxt     = last;
              wr_pend_nxt = 1'b0;
              state_nxt   = B_SH;
            end
            CMD_SAMPLE: state_nxt = B_SRD;
            CMD_READ:   state_nxt = B_RRD;
            default:    sweep = 1'b1;
          endcase
        end
      end
      B_CLR: begin
        we = 1'b1;
        if (ctr_r == AW'(MAX_COLUMNS - 1)) begin
          pend_nxt  = 1'b0;
          state_nxt = B_IDLE;
        end else begin
          ctr_nxt = ctr_r + AW'(1);
        end
      end
      B_WIPE: begin
        we = 1'b1;
        if (ctr_r == last) begin
          any_nxt   = 1'b0;
          mn_nxt    = '0;
          mx_nxt    = '0;
          state_nxt = B_OUT;
        end else begin
          ctr_nxt = ctr_r + AW'(1);
        end
      end
      B_SH: begin
        ra          = ctr_r - s_r;
        we          = wr_pend_r;
        wa          = wa_r;
        wd          = rd_r;
        wr_pend_nxt = 1'b1;
        wa_nxt      = ctr_r;
        if (ctr_r == s_r) begin
          state_nxt = B_SHLAST;
        end else begin
          ctr_nxt = ctr_r - AW'(1);
        end
      end
      B_SHLAST: begin
        we          = 1'b1;
        wa          = wa_r;
        wd          = rd_r;
        wr_pend_nxt = 1'b0;
        ctr_nxt     = s_r - AW'(1);
        state_nxt   = B_SHCLR;
      end
      B_SHCLR: begin
        we = 1'b1;
        if (ctr_r == '0) begin
          sweep = 1'b1;
        end else begin
          ctr_nxt = ctr_r - AW'(1);
        end
      end
      B_SRD: begin
        ra        = AW'(cmd_r.col);
        state_nxt = B_SWR;
      end
      B_SWR: begin
        wa = AW'(cmd_r.col);
        wd = '{valid: 1'b1, cur: cmd_r.cur, volt: cmd_r.volt};
        we = !rd_r.valid || (cmd_r.cur > rd_r.cur);
        sweep = 1'b1;
      end
      B_RRD: begin
        ra        = AW'(cmd_r.col);
        state_nxt = B_RCAP;
      end
      B_RCAP: begin
        if (rd_r.valid) begin
          cc_nxt = rd_r.cur;
          cv_nxt = rd_r.volt;
          ok_nxt = 1'b1;
        end
        sweep = 1'b1;
      end
      B_SW: begin
        sw_pend_nxt = 1'b1;
        if (sw_pend_r) begin
          any_nxt = acc_any;
          mn_nxt  = acc_mn;
          mx_nxt  = acc_mx;
        end
        if (ctr_r == last) begin
          state_nxt = B_SWEND;
        end else begin
          ctr_nxt = ctr_r + AW'(1);
        end
      end
      B_SWEND: begin
        any_nxt   = acc_any;
        mn_nxt    = acc_mn;
        mx_nxt    = acc_mx;
        state_nxt = B_OUT;
      end
      B_OUT: begin
        if (!ov_r || out_ch.ready) begin
          load      = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
    if (sweep) begin
      ctr_nxt     = '0;
      sw_pend_nxt = 1'b0;
      any_nxt     = 1'b0;
      mn_nxt      = '0;
      mx_nxt      = '0;
      state_nxt   = (w == '0) ? B_OUT : B_SW;
    end
    if (cfg_ev.cols_wr) begin
      pend_nxt      = 1'b1;
      pend_from_nxt = (pend_r && pend_from_r < new_w) ? pend_from_r : new_w;
      if (state_r == B_CLR) begin
        state_nxt = B_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      pend_r      <= 1'b1;
      pend_from_r <= '0;
      wr_pend_r   <= 1'b0;
      sw_pend_r   <= 1'b0;
      ov_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      pend_from_r <= pend_from_nxt;
      wr_pend_r   <= wr_pend_nxt;
      sw_pend_r   <= sw_pend_nxt;
      if (load) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ctr_r <= ctr_nxt;
    s_r   <= s_nxt;
    wa_r  <= wa_nxt;
    cmd_r <= cmd_nxt;
    any_r <= any_nxt;
    mn_r  <= mn_nxt;
    mx_r  <= mx_nxt;
    cc_r  <= cc_nxt;
    cv_r  <= cv_nxt;
    ok_r  <= ok_nxt;
    if (load) begin
      o_cc_r  <= cc_r;
      o_cv_r  <= cv_r;
      o_ok_r  <= ok_r;
      o_mn_r  <= mn_r;
      o_mx_r  <= mx_r;
      o_any_r <= any_r;
    end
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.col_current = o_cc_r;
  assign out_ch.col_voltage = o_cv_r;
  assign out_ch.col_valid   = o_ok_r;
  assign out_ch.min_current = o_mn_r;
  assign out_ch.max_current = o_mx_r;
  assign out_ch.has_data    = o_any_r;
endmodule
`default_nettype wire

>>> rtl/peak_hold_strip_chart_binner.sv
// top level of the peak-hold strip-chart binner
//
// in_ch takes one item per transfer: rebuild, advance, sample or column read.
// out_ch gives one result per item: the read column (zero unless a read) and
// min/max current over the valid columns in use. cfg_we/cfg_idx/cfg_data
// write interval, log scale and column count; write only while idle.
// The front end divides a sample's or advance's time offset by the interval,
// one quotient bit per cycle, and hands a column command to a two-deep
// queue. The back end runs the command on the column memory (one read and
// one write port): rebuild wipes W columns, advance shifts the columns by
// its step at one per cycle and clears the freed ones, sample and read look
// up their column; then a sweep over the W columns forms min/max.
// Rebuild skips the sweep. After reset the memory is cleared with in_ch not
// ready; any write of the column count clears the columns at and above the
// new count the same way.
// A stalled receiver holds the result register; the next item still runs
// through the front end and queue and waits in the back end.
`default_nettype none
module peak_hold_strip_chart_binner import phsc_pkg::*; #(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  phsc_in_if.sink                       in_ch,
  phsc_out_if.source                    out_ch,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);
  localparam int CW = $clog2(MAX_COLUMNS + 1);

  logic [INTERVAL_BITS-1:0] interval_r;
  logic                     log_r;
  logic [COLS_REG_BITS-1:0] cols_r;
  logic [CW-1:0]            w, new_w;
  logic                     edge_clr;
  cfg_ev_t                  cfg_ev;
  logic                     push_valid, push_ready, pop_valid, pop_ready, clr_busy;
  cmd_t                     push_cmd, pop_cmd;

  assign w     = (32'(cols_r) > 32'(MAX_COLUMNS)) ? CW'(MAX_COLUMNS) : CW'(cols_r);
  assign new_w = (32'(cfg_data[COLS_REG_BITS-1:0]) > 32'(MAX_COLUMNS))
                 ? CW'(MAX_COLUMNS) : CW'(cfg_data[COLS_REG_BITS-1:0]);

  always_comb begin
    edge_clr       = 1'b0;
    cfg_ev.cols_wr = 1'b0;
    cfg_ev.new_w   = WIDTH_BITS'(new_w);
    if (cfg_we) begin
      case (reg_idx_t'(cfg_idx))
        REG_INTERVAL:  edge_clr = cfg_data != interval_r;
        REG_LOG_SCALE: edge_clr = cfg_data[0] != log_r;
        REG_COLUMNS:   cfg_ev.cols_wr = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= INTERVAL_BITS'(INTERVAL_RESET);
      log_r      <= 1'b0;
      cols_r     <= COLS_REG_BITS'(COLS_RESET);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_idx))
        REG_INTERVAL:  interval_r <= cfg_data;
        REG_LOG_SCALE: log_r      <= cfg_data[0];
        REG_COLUMNS:   cols_r     <= cfg_data[COLS_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  phsc_front #(.MAX_COLUMNS(MAX_COLUMNS), .TIME_BITS(TIME_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .clr_busy   (clr_busy),
    .edge_clr   (edge_clr),
    .interval   (interval_r),
    .log_scale  (log_r),
    .w          (w),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  phsc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  phsc_back #(.MAX_COLUMNS(MAX_COLUMNS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .cfg_ev    (cfg_ev),
    .w         (w),
    .clr_busy  (clr_busy),
    .out_ch    (out_ch)
  );
endmodule
`default_nettype wire

>>> rtl/phsc_checker.sv
// port-level checks on the result channel, bound to the top level
`default_nettype none
module phsc_checker import phsc_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [CUR_BITS-1:0]  out_col_current,
  input wire logic [VOLT_BITS-1:0] out_col_voltage,
  input wire logic                 out_col_valid,
  input wire logic [CUR_BITS-1:0]  out_min_current,
  input wire logic [CUR_BITS-1:0]  out_max_current,
  input wire logic                 out_has_data
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_col_current)
      && $stable(out_max_current) && $stable(out_min_current))
    else $error("result changed while stalled");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_data |-> out_min_current == '0 && out_max_current == '0)
    else $error("min/max nonzero with no data");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_data |-> out_min_current <= out_max_current)
    else $error("min above max");

  a_novalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_col_valid |-> out_col_current == '0 && out_col_voltage == '0)
    else $error("column data without valid");

  a_inrange: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_col_valid |-> out_has_data && out_col_current >= out_min_current
      && out_col_current <= out_max_current)
    else $error("read column outside min/max");
endmodule

bind peak_hold_strip_chart_binner phsc_checker u_phsc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_col_current (out_ch.col_current),
  .out_col_voltage (out_ch.col_voltage),
  .out_col_valid   (out_ch.col_valid),
  .out_min_current (out_ch.min_current),
  .out_max_current (out_ch.max_current),
  .out_has_data    (out_ch.has_data)
);
`default_nettype wire
